FILE: rtl/core/rne_pkg.sv
// rne_pkg: shared types, constants and digit-expansion functions for the
// roman numeral encoder. No dependencies.

package rne_pkg;

    localparam int VALUE_W    = 12;
    localparam int DIGIT_W    = 4;
    localparam int NUM_DIGITS = 4;
    localparam int IDX_W      = 2;
    localparam int POS_W      = 2;
    localparam int LEN_W      = 3;
    localparam int SYM_W      = 3;

    localparam logic [VALUE_W-1:0] MAX_VALUE = VALUE_W'(3999);

    // decade positions, thousands is the top digit
    localparam logic [IDX_W-1:0] IDX_UNITS     = 2'd0;
    localparam logic [IDX_W-1:0] IDX_TENS      = 2'd1;
    localparam logic [IDX_W-1:0] IDX_HUNDREDS  = 2'd2;
    localparam logic [IDX_W-1:0] IDX_THOUSANDS = 2'd3;

    localparam int unsigned SCALE_TENS      = 10;
    localparam int unsigned SCALE_HUNDREDS  = 100;
    localparam int unsigned SCALE_THOUSANDS = 1000;

    localparam logic [SYM_W-1:0] SYM_I = 3'd0;
    localparam logic [SYM_W-1:0] SYM_V = 3'd1;
    localparam logic [SYM_W-1:0] SYM_X = 3'd2;
    localparam logic [SYM_W-1:0] SYM_L = 3'd3;
    localparam logic [SYM_W-1:0] SYM_C = 3'd4;
    localparam logic [SYM_W-1:0] SYM_D = 3'd5;
    localparam logic [SYM_W-1:0] SYM_M = 3'd6;

    typedef enum logic [1:0] {
        KIND_ONE,
        KIND_FIVE,
        KIND_TEN
    } t_kind;

    typedef enum logic [1:0] {
        FR_IDLE,
        FR_CONV,
        FR_PUSH
    } t_front_state;

    typedef enum logic {
        BK_IDLE,
        BK_RUN
    } t_back_state;

    // digits[3] is thousands, digits[0] is units
    typedef struct packed {
        logic                                err;
        logic [NUM_DIGITS-1:0][DIGIT_W-1:0] digits;
    } t_entry;

    // largest k in 0..9 with k * scale not above rem
    function automatic logic [DIGIT_W-1:0] decade_digit(input logic [VALUE_W-1:0] rem,
                                                        input int unsigned        scale);
        logic [DIGIT_W-1:0] d;
        d = '0;
        for (int unsigned k = 1; k < 10; k++) begin
            if (32'(rem) >= k * scale) begin
                d = DIGIT_W'(k);
            end
        end
        return d;
    endfunction

    // rem less the largest multiple of scale (up to 9) that fits
    function automatic logic [VALUE_W-1:0] decade_rem(input logic [VALUE_W-1:0] rem,
                                                      input int unsigned        scale);
        logic [VALUE_W-1:0] r;
        r = rem;
        for (int unsigned k = 1; k < 10; k++) begin
            if (32'(rem) >= k * scale) begin
                r = rem - VALUE_W'(k * scale);
            end
        end
        return r;
    endfunction

    function automatic logic [LEN_W-1:0] digit_len(input logic [DIGIT_W-1:0] d);
        logic [LEN_W-1:0] len;
        case (d)
            4'd0:    len = 3'd0;
            4'd1:    len = 3'd1;
            4'd2:    len = 3'd2;
            4'd3:    len = 3'd3;
            4'd4:    len = 3'd2;
            4'd5:    len = 3'd1;
            4'd6:    len = 3'd2;
            4'd7:    len = 3'd3;
            4'd8:    len = 3'd4;
            4'd9:    len = 3'd2;
            default: len = 3'd0;
        endcase
        return len;
    endfunction

    function automatic t_kind digit_kind(input logic [DIGIT_W-1:0] d,
                                         input logic [POS_W-1:0]   pos);
        t_kind kind;
        case (d)
            4'd4:    kind = (pos == '0) ? KIND_ONE : KIND_FIVE;
            4'd5, 4'd6, 4'd7, 4'd8:
                     kind = (pos == '0) ? KIND_FIVE : KIND_ONE;
            4'd9:    kind = (pos == '0) ? KIND_ONE : KIND_TEN;
            default: kind = KIND_ONE;
        endcase
        return kind;
    endfunction

    // one-symbol of decade idx is 2*idx, five is next, ten is the one after
    function automatic logic [SYM_W-1:0] kind_symbol(input logic [IDX_W-1:0] idx,
                                                     input t_kind            kind);
        logic [SYM_W-1:0] base;
        logic [SYM_W-1:0] sym;
        base = {idx, 1'b0};
        case (kind)
            KIND_ONE:  sym = base;
            KIND_FIVE: sym = base + SYM_V;
            KIND_TEN:  sym = base + SYM_X;
            default:   sym = base;
        endcase
        return sym;
    endfunction

endpackage

FILE: rtl/core/rne_front.sv
// rne_front: accepts a number, flags out-of-range values and splits it into
// decimal digits, a compare-and-subtract step per upper digit. Uses rne_pkg.

module rne_front (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [rne_pkg::VALUE_W-1:0]   i_value,
    output logic                          o_push_valid,
    input  logic                          i_push_ready,
    output rne_pkg::t_entry               o_entry
);

    rne_pkg::t_front_state r_state;
    rne_pkg::t_front_state n_state;

    logic [rne_pkg::VALUE_W-1:0]                          r_rem;
    logic [rne_pkg::VALUE_W-1:0]                          n_rem;
    logic [rne_pkg::NUM_DIGITS-1:1][rne_pkg::DIGIT_W-1:0] r_upper;
    logic [rne_pkg::DIGIT_W-1:0]                          digit;
    logic [rne_pkg::IDX_W-1:0]                            r_step;
    logic                                                 r_err;

    // thousands, then hundreds, then tens; what is left is the units digit
    always_comb begin
        case (r_step)
            rne_pkg::IDX_THOUSANDS: begin
                digit = rne_pkg::decade_digit(r_rem, rne_pkg::SCALE_THOUSANDS);
                n_rem = rne_pkg::decade_rem(r_rem, rne_pkg::SCALE_THOUSANDS);
            end
            rne_pkg::IDX_HUNDREDS: begin
                digit = rne_pkg::decade_digit(r_rem, rne_pkg::SCALE_HUNDREDS);
                n_rem = rne_pkg::decade_rem(r_rem, rne_pkg::SCALE_HUNDREDS);
            end
            rne_pkg::IDX_TENS: begin
                digit = rne_pkg::decade_digit(r_rem, rne_pkg::SCALE_TENS);
                n_rem = rne_pkg::decade_rem(r_rem, rne_pkg::SCALE_TENS);
            end
            default: begin
                digit = '0;
                n_rem = r_rem;
            end
        endcase
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            rne_pkg::FR_IDLE: begin
                if (i_valid) begin
                    n_state = rne_pkg::FR_CONV;
                end
            end
            rne_pkg::FR_CONV: begin
                if (r_step == rne_pkg::IDX_TENS) begin
                    n_state = rne_pkg::FR_PUSH;
                end
            end
            rne_pkg::FR_PUSH: begin
                if (i_push_ready) begin
                    n_state = rne_pkg::FR_IDLE;
                end
            end
            default: n_state = rne_pkg::FR_IDLE;
        endcase
    end

    always_comb begin
        o_ready        = (r_state == rne_pkg::FR_IDLE);
        o_push_valid   = (r_state == rne_pkg::FR_PUSH);
        o_entry.err    = r_err;
        o_entry.digits = {r_upper, r_rem[rne_pkg::DIGIT_W-1:0]};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= rne_pkg::FR_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == rne_pkg::FR_IDLE && i_valid) begin
            r_rem  <= i_value;
            r_step <= rne_pkg::IDX_THOUSANDS;
            r_err  <= (i_value == '0) || (i_value > rne_pkg::MAX_VALUE);
        end else if (r_state == rne_pkg::FR_CONV) begin
            r_rem            <= n_rem;
            r_upper[r_step]  <= digit;
            r_step           <= r_step - 1'b1;
        end
    end

endmodule

FILE: rtl/core/rne_queue.sv
// rne_queue: small register queue of classified numbers between the digit
// splitter and the symbol sequencer. Uses rne_pkg.

module rne_queue #(
    parameter int DEPTH = 2
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push_valid,
    output logic            o_push_ready,
    input  rne_pkg::t_entry i_entry,
    output logic            o_pop_valid,
    input  logic            i_pop_ready,
    output rne_pkg::t_entry o_entry
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    rne_pkg::t_entry r_mem [DEPTH];

    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             push;
    logic             pop;

    always_comb begin
        o_push_ready = (r_count != FULL_CNT);
        o_pop_valid  = (r_count != '0);
        push         = i_push_valid && o_push_ready;
        pop          = o_pop_valid && i_pop_ready;
        o_entry      = r_mem[r_rd_ptr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + 1'b1;
            end
            if (pop) begin
                r_rd_ptr <= (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + 1'b1;
            end
            if (push && !pop) begin
                r_count <= r_count + 1'b1;
            end else if (pop && !push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

endmodule

FILE: rtl/core/rne_back.sv
// rne_back: walks the digits of one queued number and emits one numeral symbol
// per cycle unless output stalls, into a registered stage. Uses rne_pkg.

module rne_back (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_pop_valid,
    output logic                        o_pop_ready,
    input  rne_pkg::t_entry             i_entry,
    output logic                        o_m_valid,
    input  logic                        i_m_ready,
    output logic [rne_pkg::SYM_W-1:0]   o_m_symbol,
    output logic                        o_m_last,
    output logic                        o_m_oor
);

    rne_pkg::t_back_state r_state;
    rne_pkg::t_back_state n_state;

    logic                                                 r_err;
    logic                                                 n_err;
    logic [rne_pkg::NUM_DIGITS-1:0][rne_pkg::DIGIT_W-1:0] r_digits;
    logic [rne_pkg::NUM_DIGITS-1:0][rne_pkg::DIGIT_W-1:0] n_digits;
    logic [rne_pkg::IDX_W-1:0]                            r_idx;
    logic [rne_pkg::IDX_W-1:0]                            n_idx;
    logic [rne_pkg::POS_W-1:0]                            r_pos;
    logic [rne_pkg::POS_W-1:0]                            n_pos;
    logic                                                 r_m_valid;
    logic                                                 n_m_valid;
    logic [rne_pkg::SYM_W-1:0]                            r_sym;
    logic [rne_pkg::SYM_W-1:0]                            n_sym;
    logic                                                 r_last;
    logic                                                 n_last;
    logic                                                 r_oor;
    logic                                                 n_oor;

    logic [rne_pkg::DIGIT_W-1:0] cur_digit;
    logic [rne_pkg::LEN_W-1:0]   cur_len;
    logic [rne_pkg::SYM_W-1:0]   cur_sym;
    logic                        end_digit;
    logic                        any_lower;
    logic [rne_pkg::IDX_W-1:0]   lower_idx;
    logic [rne_pkg::IDX_W-1:0]   first_idx;
    logic                        advance;
    logic                        run_done;

    always_comb begin
        cur_digit = r_digits[r_idx];
        cur_len   = rne_pkg::digit_len(cur_digit);
        cur_sym   = rne_pkg::kind_symbol(r_idx, rne_pkg::digit_kind(cur_digit, r_pos));
        end_digit = (rne_pkg::LEN_W'(r_pos) + 1'b1) == cur_len;
        advance   = !r_m_valid || i_m_ready;

        // highest nonzero digit below the current one, zero digits are skipped
        any_lower = 1'b0;
        lower_idx = '0;
        first_idx = '0;
        for (int k = 0; k < rne_pkg::NUM_DIGITS; k++) begin
            if (rne_pkg::IDX_W'(k) < r_idx && r_digits[k] != '0) begin
                any_lower = 1'b1;
                lower_idx = rne_pkg::IDX_W'(k);
            end
            if (i_entry.digits[k] != '0) begin
                first_idx = rne_pkg::IDX_W'(k);
            end
        end
        run_done = r_err || (end_digit && !any_lower);
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            rne_pkg::BK_IDLE: begin
                if (i_pop_valid) begin
                    n_state = rne_pkg::BK_RUN;
                end
            end
            rne_pkg::BK_RUN: begin
                if (advance && run_done) begin
                    n_state = rne_pkg::BK_IDLE;
                end
            end
            default: n_state = rne_pkg::BK_IDLE;
        endcase
    end

    always_comb begin
        o_pop_ready = (r_state == rne_pkg::BK_IDLE);
        o_m_valid   = r_m_valid;
        o_m_symbol  = r_sym;
        o_m_last    = r_last;
        o_m_oor     = r_oor;

        n_err     = r_err;
        n_digits  = r_digits;
        n_idx     = r_idx;
        n_pos     = r_pos;
        n_m_valid = r_m_valid && !i_m_ready;
        n_sym     = r_sym;
        n_last    = r_last;
        n_oor     = r_oor;

        case (r_state)
            rne_pkg::BK_IDLE: begin
                if (i_pop_valid) begin
                    n_err    = i_entry.err;
                    n_digits = i_entry.digits;
                    n_idx    = first_idx;
                    n_pos    = '0;
                end
            end
            rne_pkg::BK_RUN: begin
                if (advance) begin
                    n_m_valid = 1'b1;
                    if (r_err) begin
                        n_sym  = rne_pkg::SYM_I;
                        n_last = 1'b1;
                        n_oor  = 1'b1;
                    end else begin
                        n_sym  = cur_sym;
                        n_last = end_digit && !any_lower;
                        n_oor  = 1'b0;
                        if (end_digit) begin
                            n_idx = lower_idx;
                            n_pos = '0;
                        end else begin
                            n_pos = r_pos + 1'b1;
                        end
                    end
                end
            end
            default: begin
                n_m_valid = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= rne_pkg::BK_IDLE;
            r_m_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_m_valid <= n_m_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_err    <= n_err;
        r_digits <= n_digits;
        r_idx    <= n_idx;
        r_pos    <= n_pos;
        r_sym    <= n_sym;
        r_last   <= n_last;
        r_oor    <= n_oor;
    end

endmodule

FILE: rtl/core/roman_numeral_encoder.sv
// roman_numeral_encoder: top level, digit splitter, queue and symbol
// sequencer. Uses rne_pkg, rne_front, rne_queue and rne_back.
//
//   channel   dir  payload                       marker
//   s_axis    in   tdata[11:0] value             -
//   m_axis    out  tdata[2:0] symbol             tlast = last, tuser = out_of_range
//
// a number is accepted, goes through 3 compare-and-subtract steps (thousands,
// hundreds, tens) and is handed off to the queue by the front; the back
// then loads it and emits one symbol per cycle (1 to 15 symbols) while
// m_axis_tready does not stall it.
// reset is synchronous, active low; no clearing pass is needed.
// the queue lets the splitter work on the next number while the sequencer
// is stalled by m_axis_tready.

module roman_numeral_encoder #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // [11:0] value, [15:12] zero
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // [2:0] symbol, [7:3] zero
    output logic        m_axis_tlast,
    output logic [0:0]  m_axis_tuser    // [0] out_of_range
);

    rne_pkg::t_entry             front_entry;
    rne_pkg::t_entry             queue_entry;
    logic                        push_valid;
    logic                        push_ready;
    logic                        pop_valid;
    logic                        pop_ready;
    logic [rne_pkg::SYM_W-1:0]   symbol;
    logic                        oor;

    rne_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (s_axis_tvalid),
        .o_ready      (s_axis_tready),
        .i_value      (s_axis_tdata[rne_pkg::VALUE_W-1:0]),
        .o_push_valid (push_valid),
        .i_push_ready (push_ready),
        .o_entry      (front_entry)
    );

    rne_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (push_valid),
        .o_push_ready (push_ready),
        .i_entry      (front_entry),
        .o_pop_valid  (pop_valid),
        .i_pop_ready  (pop_ready),
        .o_entry      (queue_entry)
    );

    rne_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_pop_valid (pop_valid),
        .o_pop_ready (pop_ready),
        .i_entry     (queue_entry),
        .o_m_valid   (m_axis_tvalid),
        .i_m_ready   (m_axis_tready),
        .o_m_symbol  (symbol),
        .o_m_last    (m_axis_tlast),
        .o_m_oor     (oor)
    );

    assign m_axis_tdata = {5'b0, symbol};
    assign m_axis_tuser = oor;

endmodule
